>>> design/assert_macros.svh
// Assertion helpers; both expect clk_i in scope, and MF3_ASSERT also rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MF3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mf3 check failed");

// Checked at every edge, reset included.
`define MF3_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mf3 check failed");

`endif

>>> design/mf3_pkg.sv
package mf3_pkg;

  localparam int FW_BITS    = 11;
  localparam int FH_BITS    = 13;
  localparam int CFG_BITS   = 13;
  localparam int ROW_BITS   = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int RST_WIDTH  = 512;
  localparam int RST_HEIGHT = 512;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic last_row;
    logic last_frame;
  } mf3_tag_t;

endpackage

>>> design/median_filter_3x3.sv
// 3x3 median filter for a raster stream of gray pixels. Frame size comes from the
// frame_width and frame_height registers (cfg index 0 and 1, clamped to 1..MAX_WIDTH
// and 1..4096); a write restarts the frame. Pixels outside the frame count as zero.
// Results trail the input by one row plus one pixel, so after the W*H pixels of a
// frame send W+1 beats with tuser (flush) set; the beat after the flush row ends
// the frame and emits its last result. The block takes one beat per clock while
// the output is not stalled, bounded by the single line-buffer RAM that does one
// read and one write each cycle; a result passes the stage-1 registers, then p2,
// p3, p4 and med_q. Line buffer contents need no clearing: rows not yet written
// in the current frame are masked to zero.
module median_filter_3x3
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  cfg_reg_e                               cfg_idx_i,
  input  logic [CFG_BITS-1:0]                    cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,  // pixel
  input  logic                                   s_axis_tuser,  // flush
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((PIXEL_BITS + 7) / 8) * 8-1:0]  m_axis_tdata,  // median
  output logic                                   m_axis_tlast,  // last_in_row
  output logic                                   m_axis_tuser   // last_in_frame
);

  localparam int DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_BITS = (FW_BITS > WID_BITS) ? FW_BITS : WID_BITS;
  localparam int RST_W     = (MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [2:0]            col_t;
  typedef pix_t [8:0]            win_t;

  function automatic win_t cx(input win_t p, input logic [3:0] a, input logic [3:0] b);
    win_t r;
    r = p;
    if (p[a] > p[b]) begin
      r[a] = p[b];
      r[b] = p[a];
    end
    return r;
  endfunction

  function automatic win_t med_a(input win_t p);
    win_t r;
    r = cx(p, 4'd1, 4'd2);
    r = cx(r, 4'd4, 4'd5);
    r = cx(r, 4'd7, 4'd8);
    r = cx(r, 4'd0, 4'd1);
    r = cx(r, 4'd3, 4'd4);
    r = cx(r, 4'd6, 4'd7);
    r = cx(r, 4'd1, 4'd2);
    r = cx(r, 4'd4, 4'd5);
    r = cx(r, 4'd7, 4'd8);
    return r;
  endfunction

  function automatic win_t med_b(input win_t p);
    win_t r;
    r = cx(p, 4'd0, 4'd3);
    r = cx(r, 4'd5, 4'd8);
    r = cx(r, 4'd4, 4'd7);
    r = cx(r, 4'd3, 4'd6);
    r = cx(r, 4'd1, 4'd4);
    r = cx(r, 4'd2, 4'd5);
    r = cx(r, 4'd4, 4'd7);
    return r;
  endfunction

  function automatic pix_t med_c(input win_t p);
    win_t r;
    r = cx(p, 4'd4, 4'd2);
    r = cx(r, 4'd6, 4'd4);
    r = cx(r, 4'd4, 4'd2);
    return r[4];
  endfunction

  // configuration
  logic [COL_BITS-1:0]  wlast_q, wlast_d;
  logic                 wide2_q, wide2_d;
  logic [ROW_BITS-1:0]  h_q, h_d, hend_q, hend_d;
  logic [WCMP_BITS-1:0] fw_ext;
  logic [FH_BITS-1:0]   fh;

  // input position
  logic [COL_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic                in_fire;

  // stage 1: line buffer data returns
  logic                  s1v_q, s1v_d;
  logic [COL_BITS-1:0]   s1_col_q;
  pix_t                  s1_bottom_q;
  logic                  s1_rge1_q, s1_rge2_q, s1_cge1_q, s1_cge2_q, s1_endf_q;
  logic                  fwd_hit_q;
  logic [2*PIXEL_BITS-1:0] fwd_data_q;
  logic [2*PIXEL_BITS-1:0] ram_rdata, ram_wdata, line;
  pix_t                  top_pix, mid_pix;
  col_t                  new_col, c1_q, c2_q, col0;
  logic                  eor, mid_emit, emit, s1_fire;

  // median pipeline
  logic     s2v_q, s2v_d, s3v_q, s3v_d, s4v_q, s4v_d, mv_q, mv_d;
  logic     s2_load, s3_load, s4_load, o_load;
  logic     s2_ready, s3_ready, s4_ready, out_ready;
  win_t     p2_q, p2_d, p3_q, p4_q;
  mf3_tag_t t2_q, t2_d, t3_q, t4_q, to_q;
  pix_t     med_q;

  assign fw_ext = WCMP_BITS'(cfg_data_i[FW_BITS-1:0]);
  assign fh     = cfg_data_i[FH_BITS-1:0];

  always_comb begin
    wlast_d = wlast_q;
    wide2_d = wide2_q;
    h_d     = h_q;
    hend_d  = hend_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH: begin
          if (fw_ext == '0) begin
            wlast_d = '0;
          end else if (fw_ext > WCMP_BITS'(MAX_WIDTH)) begin
            wlast_d = COL_BITS'(MAX_WIDTH - 1);
          end else begin
            wlast_d = COL_BITS'(fw_ext - 1'b1);
          end
          wide2_d = (fw_ext >= WCMP_BITS'(2));
        end
        CFG_FRAME_HEIGHT: begin
          if (fh == '0) begin
            h_d = ROW_BITS'(1);
          end else if (fh > FH_BITS'(MAX_HEIGHT)) begin
            h_d = ROW_BITS'(MAX_HEIGHT);
          end else begin
            h_d = ROW_BITS'(fh);
          end
          hend_d = h_d + 1'b1;
        end
        default: begin
          wlast_d = wlast_q;
        end
      endcase
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (row_q == hend_q) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == wlast_q) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // stage 1 datapath
  assign line     = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign top_pix  = s1_rge2_q ? line[PIXEL_BITS-1:0] : '0;
  assign mid_pix  = s1_rge1_q ? line[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
  assign new_col  = {s1_bottom_q, mid_pix, top_pix};
  assign ram_wdata = {s1_bottom_q, mid_pix};

  // row end: the last pixel of the row two above is finished here
  assign eor      = !s1_cge1_q && s1_rge2_q;
  assign mid_emit = s1_cge1_q && s1_rge1_q;
  assign emit     = eor || mid_emit;
  assign col0     = (eor ? wide2_q : s1_cge2_q) ? c1_q : '0;
  assign p2_d     = {(eor ? col_t'('0) : new_col), c2_q, col0};
  assign t2_d     = '{last_row: eor, last_frame: eor && s1_endf_q};

  assign out_ready = !mv_q || m_axis_tready;
  assign s4_ready  = !s4v_q || out_ready;
  assign s3_ready  = !s3v_q || s4_ready;
  assign s2_ready  = !s2v_q || s3_ready;
  assign s1_fire   = s1v_q && (!emit || s2_ready);
  assign s_axis_tready = !s1v_q || s1_fire;

  assign s2_load = s1_fire && emit;
  assign s3_load = s2v_q && s3_ready;
  assign s4_load = s3v_q && s4_ready;
  assign o_load  = s4v_q && out_ready;

  always_comb begin
    s1v_d = in_fire || (s1v_q && !s1_fire);
    s2v_d = s2_load || (s2v_q && !s3_load);
    s3v_d = s3_load || (s3v_q && !s4_load);
    s4v_d = s4_load || (s4v_q && !o_load);
    mv_d  = o_load || (mv_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= COL_BITS'(RST_W - 1);
      wide2_q <= 1'b1;
      h_q     <= ROW_BITS'(RST_HEIGHT);
      hend_q  <= ROW_BITS'(RST_HEIGHT + 1);
      col_q   <= '0;
      row_q   <= '0;
      s1v_q   <= 1'b0;
      s2v_q   <= 1'b0;
      s3v_q   <= 1'b0;
      s4v_q   <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      wlast_q <= wlast_d;
      wide2_q <= wide2_d;
      h_q     <= h_d;
      hend_q  <= hend_d;
      col_q   <= col_d;
      row_q   <= row_d;
      s1v_q   <= s1v_d;
      s2v_q   <= s2v_d;
      s3v_q   <= s3v_d;
      s4v_q   <= s4v_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q    <= col_q;
      s1_bottom_q <= (!s_axis_tuser && row_q < h_q) ? s_axis_tdata[PIXEL_BITS-1:0] : '0;
      s1_rge1_q   <= (row_q != '0);
      s1_rge2_q   <= (row_q >= ROW_BITS'(2));
      s1_cge1_q   <= (col_q != '0);
      s1_cge2_q   <= (col_q >= COL_BITS'(2));
      s1_endf_q   <= (row_q == hend_q);
      // same-address write in the read cycle: the RAM returned the old word
      fwd_hit_q   <= s1_fire && (s1_col_q == col_q);
      fwd_data_q  <= ram_wdata;
    end
    if (s1_fire) begin
      c1_q <= c2_q;
      c2_q <= new_col;
    end
    if (s2_load) begin
      p2_q <= p2_d;
      t2_q <= t2_d;
    end
    if (s3_load) begin
      p3_q <= med_a(p2_q);
      t3_q <= t2_q;
    end
    if (s4_load) begin
      p4_q <= med_b(p3_q);
      t4_q <= t3_q;
    end
    if (o_load) begin
      med_q <= med_c(p4_q);
      to_q  <= t4_q;
    end
  end

  // upper line in the low half, middle line in the high half
  mf3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = DATA_BITS'(med_q);
  assign m_axis_tlast  = to_q.last_row;
  assign m_axis_tuser  = to_q.last_frame;

endmodule

>>> design/mf3_ram.sv
module mf3_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

>>> design/mf3_checker.sv
`include "assert_macros.svh"

module mf3_checker #(
  parameter int DATA_BITS = 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [DATA_BITS-1:0] m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic                 m_axis_tuser
);

  logic seen_in_q, seen_in_d;

  assign seen_in_d = seen_in_q || (s_axis_tvalid && s_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else begin
      seen_in_q <= seen_in_d;
    end
  end

  `MF3_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))

  `MF3_ASSERT(a_frame_end_is_row_end, m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))

  `MF3_ASSERT(a_out_needs_in, m_axis_tvalid |-> seen_in_q)

  `MF3_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule

bind median_filter_3x3 mf3_checker #(
  .DATA_BITS (DATA_BITS)
) u_mf3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
